// ----- rtl/resp_cp_pkg.sv -----
// Package with the shared types and constants of the RESP command parser.
`timescale 1ns / 1ps

package resp_cp_pkg;

  // Width of the count, length and digit accumulators.
  localparam int LEN_BITS = 32;
  localparam int IDX_BITS = 32;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  typedef enum logic [3:0] {
    PH_STAR    = 4'd0,
    PH_CNT_DIG = 4'd1,
    PH_CNT_LF  = 4'd2,
    PH_DOLLAR  = 4'd3,
    PH_LEN_DIG = 4'd4,
    PH_LEN_LF  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_PAY_CR  = 4'd7,
    PH_PAY_LF  = 4'd8,
    PH_HALT    = 4'd9
  } phase_t;

  typedef enum logic [1:0] {
    EV_BYTE  = 2'd0,
    EV_ARG   = 2'd1,
    EV_EMPTY = 2'd2,
    EV_ERROR = 2'd3
  } event_t;

  typedef struct packed {
    event_t               event_res;
    logic [7:0]           data;
    logic [IDX_BITS-1:0]  arg_index;
    logic                 command_done;
  } res_t;

endpackage

// ----- rtl/resp_command_parser_core.sv -----
// Streaming parser for RESP commands made of an array of bulk strings.
`timescale 1ns / 1ps

// One raw byte is taken per transfer and the parse state is updated as it is taken,
// by a short decision plus a multiply by ten on the digit accumulator, so a new byte
// can be accepted on every clock while the skid buffer is empty. Each byte gives at most
// one result: a payload byte, an argument end (with command_done on the last one), an
// empty command complete, or a protocol error. After an error the parser halts and
// swallows every byte without a result until reset; results already sent for the
// broken command must be discarded downstream. Results go through an output register
// backed by a one-entry skid buffer, so input keeps flowing while a result waits; the
// input is stalled only while the skid buffer is occupied.
module resp_command_parser_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [7:0]                        in_byte_req,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [1:0]                        out_event_res,
  output logic [7:0]                        out_data,
  output logic [resp_cp_pkg::IDX_BITS-1:0]  out_arg_index,
  output logic                              out_command_done
);

  localparam int LB = resp_cp_pkg::LEN_BITS;
  localparam int IB = resp_cp_pkg::IDX_BITS;

  resp_cp_pkg::phase_t phase_r, phase_nxt;
  logic [LB-1:0] digit_value_r, digit_value_nxt;
  logic          digits_seen_r, digits_seen_nxt;
  logic [LB-1:0] args_left_r, args_left_nxt;
  logic [LB-1:0] payload_left_r, payload_left_nxt;
  logic [LB-1:0] arg_counter_r, arg_counter_nxt;

  resp_cp_pkg::res_t out_r, skid_r, res;
  logic out_valid_r, skid_valid_r;
  logic res_valid;
  logic accept;

  logic              is_digit;
  logic [3:0]        digit;
  logic [LB+3:0]     dv_wide;
  logic              dv_ovf;
  logic              dec_err;
  logic [LB-1:0]     pay_dec;
  logic              last_arg;
  logic [LB+IB-1:0]  idx_ext;
  logic [IB-1:0]     idx;

  assign accept   = in_valid && !in_stall;
  assign in_stall = skid_valid_r;

  assign is_digit = (in_byte_req >= resp_cp_pkg::CH_ZERO) &&
                    (in_byte_req <= resp_cp_pkg::CH_NINE);
  assign digit    = 4'(in_byte_req - resp_cp_pkg::CH_ZERO);
  // value * 10 + digit, kept four bits wider so that overflow shows in the top bits.
  assign dv_wide  = ({4'b0, digit_value_r} << 3) + ({4'b0, digit_value_r} << 1) +
                    (LB + 4)'(digit);
  assign dv_ovf   = |dv_wide[LB+3:LB];
  // A CR closes the field only if some digit came before it.
  assign dec_err  = (in_byte_req == resp_cp_pkg::CH_CR) ? !digits_seen_r
                                                        : (!is_digit || dv_ovf);
  assign pay_dec  = payload_left_r - LB'(1);
  assign last_arg = (args_left_r <= LB'(1));
  assign idx_ext  = {{IB{1'b0}}, arg_counter_r};
  assign idx      = idx_ext[IB-1:0];

  // Next phase.
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      resp_cp_pkg::PH_STAR:
        phase_nxt = (in_byte_req == resp_cp_pkg::CH_STAR) ? resp_cp_pkg::PH_CNT_DIG
                                                          : resp_cp_pkg::PH_HALT;
      resp_cp_pkg::PH_CNT_DIG, resp_cp_pkg::PH_LEN_DIG: begin
        if (dec_err) begin
          phase_nxt = resp_cp_pkg::PH_HALT;
        end else if (in_byte_req == resp_cp_pkg::CH_CR) begin
          phase_nxt = (phase_r == resp_cp_pkg::PH_CNT_DIG) ? resp_cp_pkg::PH_CNT_LF
                                                           : resp_cp_pkg::PH_LEN_LF;
        end
      end
      resp_cp_pkg::PH_CNT_LF: begin
        if (in_byte_req != resp_cp_pkg::CH_LF) begin
          phase_nxt = resp_cp_pkg::PH_HALT;
        end else begin
          phase_nxt = (digit_value_r == '0) ? resp_cp_pkg::PH_STAR
                                            : resp_cp_pkg::PH_DOLLAR;
        end
      end
      resp_cp_pkg::PH_DOLLAR:
        phase_nxt = (in_byte_req == resp_cp_pkg::CH_DOLLAR) ? resp_cp_pkg::PH_LEN_DIG
                                                            : resp_cp_pkg::PH_HALT;
      resp_cp_pkg::PH_LEN_LF: begin
        if (in_byte_req != resp_cp_pkg::CH_LF) begin
          phase_nxt = resp_cp_pkg::PH_HALT;
        end else begin
          phase_nxt = (digit_value_r == '0) ? resp_cp_pkg::PH_PAY_CR
                                            : resp_cp_pkg::PH_PAYLOAD;
        end
      end
      resp_cp_pkg::PH_PAYLOAD:
        phase_nxt = (pay_dec == '0) ? resp_cp_pkg::PH_PAY_CR : resp_cp_pkg::PH_PAYLOAD;
      resp_cp_pkg::PH_PAY_CR:
        phase_nxt = (in_byte_req == resp_cp_pkg::CH_CR) ? resp_cp_pkg::PH_PAY_LF
                                                        : resp_cp_pkg::PH_HALT;
      resp_cp_pkg::PH_PAY_LF: begin
        if (in_byte_req != resp_cp_pkg::CH_LF) begin
          phase_nxt = resp_cp_pkg::PH_HALT;
        end else begin
          phase_nxt = last_arg ? resp_cp_pkg::PH_STAR : resp_cp_pkg::PH_DOLLAR;
        end
      end
      default:
        phase_nxt = resp_cp_pkg::PH_HALT;
    endcase
  end

  // Datapath updates and the result of this byte.
  always_comb begin
    digit_value_nxt  = digit_value_r;
    digits_seen_nxt  = digits_seen_r;
    args_left_nxt    = args_left_r;
    payload_left_nxt = payload_left_r;
    arg_counter_nxt  = arg_counter_r;
    res_valid        = 1'b0;
    res.event_res    = resp_cp_pkg::EV_ERROR;
    res.data         = 8'h00;
    res.arg_index    = idx;
    res.command_done = 1'b0;
    case (phase_r)
      resp_cp_pkg::PH_STAR, resp_cp_pkg::PH_DOLLAR: begin
        digit_value_nxt = '0;
        digits_seen_nxt = 1'b0;
        res_valid       = (phase_nxt == resp_cp_pkg::PH_HALT);
      end
      resp_cp_pkg::PH_CNT_DIG, resp_cp_pkg::PH_LEN_DIG: begin
        res_valid = dec_err;
        if (!dec_err && in_byte_req != resp_cp_pkg::CH_CR) begin
          digit_value_nxt = dv_wide[LB-1:0];
          digits_seen_nxt = 1'b1;
        end
      end
      resp_cp_pkg::PH_CNT_LF: begin
        if (in_byte_req != resp_cp_pkg::CH_LF) begin
          res_valid = 1'b1;
        end else begin
          arg_counter_nxt = '0;
          args_left_nxt   = digit_value_r;
          if (digit_value_r == '0) begin
            res_valid        = 1'b1;
            res.event_res    = resp_cp_pkg::EV_EMPTY;
            res.arg_index    = '0;
            res.command_done = 1'b1;
          end
        end
      end
      resp_cp_pkg::PH_LEN_LF: begin
        if (in_byte_req != resp_cp_pkg::CH_LF) begin
          res_valid = 1'b1;
        end else begin
          payload_left_nxt = digit_value_r;
        end
      end
      resp_cp_pkg::PH_PAYLOAD: begin
        payload_left_nxt = pay_dec;
        res_valid        = 1'b1;
        res.event_res    = resp_cp_pkg::EV_BYTE;
        res.data         = in_byte_req;
      end
      resp_cp_pkg::PH_PAY_CR: begin
        res_valid = (in_byte_req != resp_cp_pkg::CH_CR);
      end
      resp_cp_pkg::PH_PAY_LF: begin
        res_valid = 1'b1;
        if (in_byte_req == resp_cp_pkg::CH_LF) begin
          res.event_res    = resp_cp_pkg::EV_ARG;
          res.command_done = last_arg;
          args_left_nxt    = last_arg ? '0 : args_left_r - LB'(1);
          arg_counter_nxt  = last_arg ? '0 : arg_counter_r + LB'(1);
        end
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= resp_cp_pkg::PH_STAR;
      digit_value_r  <= '0;
      digits_seen_r  <= 1'b0;
      args_left_r    <= '0;
      payload_left_r <= '0;
      arg_counter_r  <= '0;
    end else if (accept) begin
      phase_r        <= phase_nxt;
      digit_value_r  <= digit_value_nxt;
      digits_seen_r  <= digits_seen_nxt;
      args_left_r    <= args_left_nxt;
      payload_left_r <= payload_left_nxt;
      arg_counter_r  <= arg_counter_nxt;
    end
  end

  // Output register with skid buffer. While the skid entry is full no byte is
  // accepted, so it drains into the output register before any new result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r || !out_stall) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= accept && res_valid;
      end
    end else if (accept && res_valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid_r || !out_stall) begin
      out_r <= skid_valid_r ? skid_r : res;
    end else if (accept && res_valid) begin
      skid_r <= res;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_r.event_res;
  assign out_data         = out_r.data;
  assign out_arg_index    = out_r.arg_index;
  assign out_command_done = out_r.command_done;

  // The halt after an error is sticky.
  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == resp_cp_pkg::PH_HALT |=> phase_r == resp_cp_pkg::PH_HALT)
    else $error("parser left the halt state");

  // The skid entry is only ever filled behind a held output.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry full while output register empty");

  // A payload byte is never taken with no payload left.
  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == resp_cp_pkg::PH_PAYLOAD |-> payload_left_r != '0)
    else $error("payload phase with zero bytes left");

  // An error transfer always moves the parser into the halt state.
  a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
    accept && res_valid && res.event_res == resp_cp_pkg::EV_ERROR
      |=> phase_r == resp_cp_pkg::PH_HALT)
    else $error("error result without halt");

endmodule

// ----- test/tb_resp_command_parser_core.sv -----
// Self-checking testbench for the RESP command parser core.
`timescale 1ns / 1ps

module tb_resp_command_parser_core;

  localparam int CYCLE_LIMIT = 100000;
  localparam int LONG_HOLD   = 150;

  typedef enum int {
    BAD_START,
    EMPTY_COUNT,
    COUNT_NON_DIGIT,
    COUNT_OVERFLOW,
    COUNT_NO_LF,
    BAD_ARG_MARKER,
    EMPTY_LEN,
    LEN_NON_DIGIT,
    LEN_OVERFLOW,
    LEN_NO_LF,
    PAY_NO_CR,
    PAY_NO_LF
  } break_kind_t;

  logic                             clk = 1'b0;
  logic                             rst_n = 1'b0;
  logic                             in_valid = 1'b0;
  logic                             in_stall;
  logic [7:0]                       in_byte_req = 8'h00;
  logic                             out_valid;
  logic                             out_stall = 1'b0;
  logic [1:0]                       out_event_res;
  logic [7:0]                       out_data;
  logic [resp_cp_pkg::IDX_BITS-1:0] out_arg_index;
  logic                             out_command_done;

  resp_command_parser_core DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte_req      (in_byte_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_event_res    (out_event_res),
    .out_data         (out_data),
    .out_arg_index    (out_arg_index),
    .out_command_done (out_command_done)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stream bookkeeping.
  logic [7:0]        pending_bytes[$];
  resp_cp_pkg::res_t expected_results[$];
  int                bytes_pushed = 0;
  int                bytes_taken = 0;
  int                mismatch_count = 0;
  int                cycle_count = 0;
  logic              in_taken = 1'b0;
  logic              out_taken = 1'b0;
  logic              long_hold_req = 1'b0;
  int                send_wait = 0;
  int                send_calm = 0;
  int                recv_wait = 0;
  int                recv_calm = 0;
  int                hold_left = 0;

  // Parser state as the testbench sees it.
  resp_cp_pkg::phase_t              parse_phase = resp_cp_pkg::PH_STAR;
  logic [resp_cp_pkg::LEN_BITS-1:0] acc_value = '0;
  logic                             acc_seen = 1'b0;
  logic [resp_cp_pkg::LEN_BITS-1:0] args_remaining = '0;
  logic [resp_cp_pkg::LEN_BITS-1:0] bytes_remaining = '0;
  logic [resp_cp_pkg::LEN_BITS-1:0] arg_num = '0;
  logic [resp_cp_pkg::LEN_BITS-1:0] len_top = '1;

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("MISMATCH at cycle %0d: %s: got %0h, expected %0h", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  task automatic queue_result(input resp_cp_pkg::event_t ev, input logic [7:0] dat,
                              input logic [resp_cp_pkg::LEN_BITS-1:0] idx,
                              input logic done);
    resp_cp_pkg::res_t r;
    r.event_res      = ev;
    r.data           = dat;
    r.arg_index      = idx;
    r.command_done   = done;
    expected_results = {expected_results, r};
  endtask

  task automatic raise_error();
    parse_phase = resp_cp_pkg::PH_HALT;
    queue_result(resp_cp_pkg::EV_ERROR, 8'h00, arg_num, 1'b0);
  endtask

  task automatic predict_byte(input logic [7:0] b);
    logic [resp_cp_pkg::LEN_BITS-1:0] digit;
    logic                             last;
    digit = b - resp_cp_pkg::CH_ZERO;
    case (parse_phase)
      resp_cp_pkg::PH_STAR: begin
        if (b != resp_cp_pkg::CH_STAR) raise_error();
        else begin
          acc_value   = '0;
          acc_seen    = 1'b0;
          parse_phase = resp_cp_pkg::PH_CNT_DIG;
        end
      end
      resp_cp_pkg::PH_CNT_DIG, resp_cp_pkg::PH_LEN_DIG: begin
        if (b == resp_cp_pkg::CH_CR) begin
          if (!acc_seen) raise_error();
          else parse_phase = (parse_phase == resp_cp_pkg::PH_CNT_DIG) ? resp_cp_pkg::PH_CNT_LF
                                                                      : resp_cp_pkg::PH_LEN_LF;
        end else if (b < resp_cp_pkg::CH_ZERO || b > resp_cp_pkg::CH_NINE ||
                     acc_value > (len_top - digit) / 10) begin
          raise_error();
        end else begin
          acc_value = acc_value * 10 + digit;
          acc_seen  = 1'b1;
        end
      end
      resp_cp_pkg::PH_CNT_LF: begin
        if (b != resp_cp_pkg::CH_LF) raise_error();
        else begin
          arg_num = '0;
          if (acc_value == '0) begin
            parse_phase = resp_cp_pkg::PH_STAR;
            queue_result(resp_cp_pkg::EV_EMPTY, 8'h00, '0, 1'b1);
          end else begin
            args_remaining = acc_value;
            parse_phase    = resp_cp_pkg::PH_DOLLAR;
          end
        end
      end
      resp_cp_pkg::PH_DOLLAR: begin
        if (b != resp_cp_pkg::CH_DOLLAR) raise_error();
        else begin
          acc_value   = '0;
          acc_seen    = 1'b0;
          parse_phase = resp_cp_pkg::PH_LEN_DIG;
        end
      end
      resp_cp_pkg::PH_LEN_LF: begin
        if (b != resp_cp_pkg::CH_LF) raise_error();
        else begin
          bytes_remaining = acc_value;
          parse_phase     = (acc_value == '0) ? resp_cp_pkg::PH_PAY_CR
                                              : resp_cp_pkg::PH_PAYLOAD;
        end
      end
      resp_cp_pkg::PH_PAYLOAD: begin
        bytes_remaining = bytes_remaining - 1'b1;
        if (bytes_remaining == '0) parse_phase = resp_cp_pkg::PH_PAY_CR;
        queue_result(resp_cp_pkg::EV_BYTE, b, arg_num, 1'b0);
      end
      resp_cp_pkg::PH_PAY_CR: begin
        if (b != resp_cp_pkg::CH_CR) raise_error();
        else parse_phase = resp_cp_pkg::PH_PAY_LF;
      end
      resp_cp_pkg::PH_PAY_LF: begin
        if (b != resp_cp_pkg::CH_LF) raise_error();
        else begin
          last = (args_remaining <= 1);
          queue_result(resp_cp_pkg::EV_ARG, 8'h00, arg_num, last);
          if (last) begin
            args_remaining = '0;
            arg_num        = '0;
            parse_phase    = resp_cp_pkg::PH_STAR;
          end else begin
            args_remaining = args_remaining - 1'b1;
            arg_num        = arg_num + 1'b1;
            parse_phase    = resp_cp_pkg::PH_DOLLAR;
          end
        end
      end
      default: parse_phase = resp_cp_pkg::PH_HALT;
    endcase
  endtask

  // Idle cycles before the next transfer, with calm stretches of no idling.
  function automatic int draw_wait(inout int calm_left);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) calm_left = $urandom_range(20, 60);
    return $urandom_range(0, 6);
  endfunction

  // Sender: the byte is held steady until the transfer completes.
  always @(negedge clk) begin
    logic       next_valid;
    logic [7:0] next_byte;
    next_valid = in_valid;
    next_byte  = in_byte_req;
    if (in_valid && in_taken) begin
      next_valid = 1'b0;
      send_wait  = draw_wait(send_calm);
    end
    if (!next_valid && rst_n) begin
      if (send_wait > 0) send_wait--;
      else if (pending_bytes.size() != 0) begin
        next_valid = 1'b1;
        next_byte  = pending_bytes.pop_front();
      end
    end
    in_valid    <= next_valid;
    in_byte_req <= next_byte;
  end

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(negedge clk) begin
    if (long_hold_req) begin
      hold_left     = LONG_HOLD;
      long_hold_req = 1'b0;
    end
    if (out_taken) recv_wait = draw_wait(recv_calm);
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (recv_wait > 0) begin
      recv_wait--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Monitor: input transfers feed the prediction, output transfers are checked.
  always @(posedge clk) begin
    resp_cp_pkg::res_t want;
    in_taken  <= rst_n && in_valid && !in_stall;
    out_taken <= rst_n && out_valid && !out_stall;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_byte(in_byte_req);
        bytes_taken++;
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result with none expected, event", out_event_res, 0);
        end else begin
          want = expected_results.pop_front();
          if (out_event_res != want.event_res)
            report_mismatch("event_res", out_event_res, want.event_res);
          if (out_data != want.data)
            report_mismatch("data", out_data, want.data);
          if (out_arg_index != want.arg_index)
            report_mismatch("arg_index", out_arg_index, want.arg_index);
          if (out_command_done != want.command_done)
            report_mismatch("command_done", out_command_done, want.command_done);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycle_count);
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_byte(input logic [7:0] b);
    pending_bytes = {pending_bytes, b};
    bytes_pushed++;
  endtask

  task automatic push_digits(input longint unsigned value);
    logic [7:0] digits[$];
    do begin
      digits.push_front(resp_cp_pkg::CH_ZERO + 8'(value % 10));
      value = value / 10;
    end while (value != 0);
    foreach (digits[i]) push_byte(digits[i]);
  endtask

  task automatic push_crlf();
    push_byte(resp_cp_pkg::CH_CR);
    push_byte(resp_cp_pkg::CH_LF);
  endtask

  // Marker, decimal value (now and then with leading zeros) and line end.
  task automatic push_header(input logic [7:0] marker, input longint unsigned value);
    push_byte(marker);
    if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 2)) push_byte(resp_cp_pkg::CH_ZERO);
    push_digits(value);
    push_crlf();
  endtask

  task automatic push_arg(input int len);
    push_header(resp_cp_pkg::CH_DOLLAR, len);
    repeat (len) push_byte(8'($urandom_range(0, 255)));
    push_crlf();
  endtask

  task automatic push_command();
    int n_args;
    n_args = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 4);
    push_header(resp_cp_pkg::CH_STAR, n_args);
    repeat (n_args) push_arg(($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                         : $urandom_range(0, 6));
  endtask

  function automatic logic [7:0] byte_other_than(input logic [7:0] avoid);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255)); while (b == avoid);
    return b;
  endfunction

  function automatic logic [7:0] non_digit_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while ((b >= resp_cp_pkg::CH_ZERO && b <= resp_cp_pkg::CH_NINE) ||
           b == resp_cp_pkg::CH_CR);
    return b;
  endfunction

  // One protocol violation of a randomly chosen sort; the parser halts after it.
  task automatic push_broken_command();
    break_kind_t kind;
    kind = break_kind_t'($urandom_range(0, PAY_NO_LF));
    if (kind >= BAD_ARG_MARKER) begin
      // One good argument first, so that the error carries a non-zero index.
      push_header(resp_cp_pkg::CH_STAR, 3);
      push_arg(1);
    end
    case (kind)
      BAD_START: push_byte(byte_other_than(resp_cp_pkg::CH_STAR));
      EMPTY_COUNT: begin
        push_byte(resp_cp_pkg::CH_STAR);
        push_byte(resp_cp_pkg::CH_CR);
      end
      COUNT_NON_DIGIT: begin
        push_byte(resp_cp_pkg::CH_STAR);
        if ($urandom_range(0, 1) == 1) push_digits($urandom_range(0, 99));
        push_byte(non_digit_byte());
      end
      COUNT_OVERFLOW: begin
        push_byte(resp_cp_pkg::CH_STAR);
        push_digits(len_top);
        push_byte(resp_cp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
      COUNT_NO_LF: begin
        push_byte(resp_cp_pkg::CH_STAR);
        push_digits($urandom_range(0, 9));
        push_byte(resp_cp_pkg::CH_CR);
        push_byte(byte_other_than(resp_cp_pkg::CH_LF));
      end
      BAD_ARG_MARKER: push_byte(byte_other_than(resp_cp_pkg::CH_DOLLAR));
      EMPTY_LEN: begin
        push_byte(resp_cp_pkg::CH_DOLLAR);
        push_byte(resp_cp_pkg::CH_CR);
      end
      LEN_NON_DIGIT: begin
        push_byte(resp_cp_pkg::CH_DOLLAR);
        if ($urandom_range(0, 1) == 1) push_digits($urandom_range(0, 99));
        push_byte(non_digit_byte());
      end
      LEN_OVERFLOW: begin
        push_byte(resp_cp_pkg::CH_DOLLAR);
        push_digits(len_top);
        push_byte(resp_cp_pkg::CH_ZERO + 8'($urandom_range(0, 9)));
      end
      LEN_NO_LF: begin
        push_byte(resp_cp_pkg::CH_DOLLAR);
        push_digits(1);
        push_byte(resp_cp_pkg::CH_CR);
        push_byte(byte_other_than(resp_cp_pkg::CH_LF));
      end
      PAY_NO_CR: begin
        push_header(resp_cp_pkg::CH_DOLLAR, 2);
        repeat (2) push_byte(8'($urandom_range(0, 255)));
        push_byte(byte_other_than(resp_cp_pkg::CH_CR));
      end
      default: begin
        push_header(resp_cp_pkg::CH_DOLLAR, 2);
        repeat (2) push_byte(8'($urandom_range(0, 255)));
        push_byte(resp_cp_pkg::CH_CR);
        push_byte(byte_other_than(resp_cp_pkg::CH_LF));
      end
    endcase
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (bytes_taken != bytes_pushed || expected_results.size() != 0);
    @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;
    @(posedge clk);

    // Empty command, a zero-length argument, and payload bytes at both extremes.
    push_header(resp_cp_pkg::CH_STAR, 0);
    push_header(resp_cp_pkg::CH_STAR, 1);
    push_header(resp_cp_pkg::CH_DOLLAR, 0);
    push_crlf();
    push_header(resp_cp_pkg::CH_STAR, 1);
    push_header(resp_cp_pkg::CH_DOLLAR, 2);
    push_byte(8'h00);
    push_byte(8'hFF);
    push_crlf();
    wait_until_drained();

    // A long payload while the receiver holds off, so that the input backs up.
    push_header(resp_cp_pkg::CH_STAR, 1);
    push_arg(48);
    while (bytes_pushed < 230) push_command();
    long_hold_req = 1'b1;
    wait_until_drained();

    while (bytes_pushed < 340) push_command();
    push_broken_command();
    // Bytes after the error must be swallowed without any result.
    repeat (30) push_byte(8'($urandom_range(0, 255)));
    wait_until_drained();
    repeat (20) @(negedge clk);

    if (expected_results.size() != 0)
      report_mismatch("results never delivered", expected_results.size(), 0);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/resp_cp_pkg.sv
rtl/resp_command_parser_core.sv
test/tb_resp_command_parser_core.sv
